### rtl/ncs_pkg.sv
// shared types, codes and command bytes for the nand command sequencer
`timescale 1ns / 1ps
`default_nettype none

package ncs_pkg;

    // geometry defaults (page size and block size are powers of two)
    localparam int PAGE_BYTES_DEF      = 2048;
    localparam int PAGES_PER_BLOCK_DEF = 64;
    localparam int ID_BYTES_DEF        = 5;

    // fixed field widths
    localparam int ADDR_W  = 28;
    localparam int COUNT_W = 29;
    localparam int PAGE_W  = 17;
    localparam int LEN_W   = 4;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // flash command bytes
    localparam logic [7:0] CMD_READ_SETUP  = 8'h00;
    localparam logic [7:0] CMD_READ_START  = 8'h30;
    localparam logic [7:0] CMD_PROG_SETUP  = 8'h80;
    localparam logic [7:0] CMD_PROG_START  = 8'h10;
    localparam logic [7:0] CMD_ERASE_SETUP = 8'h60;
    localparam logic [7:0] CMD_ERASE_START = 8'hD0;
    localparam logic [7:0] CMD_READ_ID     = 8'h90;
    localparam logic [7:0] ID_ADDR_BYTE    = 8'h00;
    localparam logic [7:0] GOOD_BLOCK_MARK = 8'hFF;

    // incoming request and event codes
    typedef enum logic [2:0] {
        REQ_READ,
        REQ_PROG,
        REQ_ERASE,
        REQ_BAD,
        REQ_ID,
        REQ_READY,
        REQ_FLASH,
        REQ_HOST
    } req_t;

    // running operation
    typedef enum logic [2:0] {
        OP_READ,
        OP_PROG,
        OP_ERASE,
        OP_BAD,
        OP_ID,
        OP_IDLE
    } op_t;

    // event the running operation waits for
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READY,
        PH_FLASH,
        PH_HOST
    } phase_t;

    // result kinds
    typedef enum logic [2:0] {
        K_CMD,
        K_ADDR,
        K_WDATA,
        K_STROBE,
        K_CSON,
        K_CSOFF,
        K_HOST,
        K_DONE
    } kind_t;

    // completion status
    typedef enum logic [1:0] {
        ST_OK,
        ST_MISALIGNED,
        ST_BAD_BLOCK,
        ST_REJECTED
    } status_t;

    // leading data beat of a job
    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_HOST,
        PRE_WDATA
    } pre_t;

    // bus sequence that follows the leading beats
    typedef enum logic [3:0] {
        BODY_NONE,
        BODY_READ,
        BODY_PROG,
        BODY_ERASE,
        BODY_ID,
        BODY_STROBE,
        BODY_FINISH,
        BODY_DONE,
        BODY_CMD10
    } body_t;

    // input beat
    typedef struct packed {
        logic [2:0]         req_type;
        logic [ADDR_W-1:0]  start_addr;
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         data_byte;
    } item_t;

    // result beat
    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } result_t;

    // one classified item, expanded into result beats by the back end
    typedef struct packed {
        pre_t              pre;
        logic [7:0]        pre_byte;
        logic              cs_on;
        body_t             body;
        logic [15:0]       col;
        logic [PAGE_W-1:0] page;
        status_t           status;
        logic [LEN_W-1:0]  len;
    } job_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        job_t job;
    } queue_head_t;

endpackage

`default_nettype wire

### rtl/ncs_front.sv
// front end: accepts items, tracks the operation state and builds jobs
`timescale 1ns / 1ps
`default_nettype none

module ncs_front #(
    parameter int PAGE_BYTES      = ncs_pkg::PAGE_BYTES_DEF,
    parameter int PAGES_PER_BLOCK = ncs_pkg::PAGES_PER_BLOCK_DEF,
    parameter int ID_BYTES        = ncs_pkg::ID_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire ncs_pkg::item_t item,
    output logic               push,
    output ncs_pkg::job_t      job,
    input  wire logic          full
);
    import ncs_pkg::*;

    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int COL_W       = PAGE_SHIFT + 1;
    localparam int BLOCK_SHIFT = $clog2(PAGE_BYTES * PAGES_PER_BLOCK);
    localparam int ID_W        = $clog2(ID_BYTES + 1);

    localparam logic [COL_W-1:0]   PAGE_END    = COL_W'(PAGE_BYTES);
    localparam logic [COUNT_W-1:0] BLOCK_BYTES = COUNT_W'(PAGE_BYTES * PAGES_PER_BLOCK);
    localparam logic [PAGE_W-1:0]  BLOCK_PAGES = PAGE_W'(PAGES_PER_BLOCK);
    localparam logic [ID_W-1:0]    ID_LAST     = ID_W'(ID_BYTES);

    // number of beats in each bus sequence
    function automatic logic [LEN_W-1:0] body_len(input body_t b);
        logic [LEN_W-1:0] n;
        unique case (b)
            BODY_READ:   n = LEN_W'(7);
            BODY_PROG:   n = LEN_W'(6);
            BODY_ERASE:  n = LEN_W'(5);
            BODY_ID:     n = LEN_W'(3);
            BODY_FINISH: n = LEN_W'(2);
            BODY_NONE:   n = '0;
            default:     n = LEN_W'(1);
        endcase
        return n;
    endfunction

    op_t                op_reg, op_next;
    phase_t             phase_reg, phase_next;
    logic [COL_W-1:0]   column_reg, column_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic [ID_W-1:0]    id_seen_reg, id_seen_next;

    req_t               req;
    logic               accept;
    logic [COL_W-1:0]   col_inc;
    logic [PAGE_W-1:0]  page_inc;
    logic [COUNT_W-1:0] left_dec;
    logic [ID_W-1:0]    id_inc;
    logic [ADDR_W-1:0]  addr_shift;
    logic [COL_W-1:0]   start_col;
    logic [PAGE_W-1:0]  start_page;
    logic               misaligned;

    assign req        = req_t'(item.req_type);
    assign accept     = item_valid && !full;
    assign push       = accept;
    assign item_stall = full;

    // address split and step values
    assign addr_shift = item.start_addr >> PAGE_SHIFT;
    assign start_page = addr_shift[PAGE_W-1:0];
    assign start_col  = COL_W'(item.start_addr[PAGE_SHIFT-1:0]);
    assign misaligned = (item.start_addr[BLOCK_SHIFT-1:0] != '0)
                     || (item.byte_count[BLOCK_SHIFT-1:0] != '0);
    assign col_inc    = column_reg + COL_W'(1);
    assign page_inc   = page_reg + PAGE_W'(1);
    assign left_dec   = (left_reg != '0) ? left_reg - COUNT_W'(1) : left_reg;
    assign id_inc     = id_seen_reg + ID_W'(1);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= OP_IDLE;
            phase_reg   <= PH_IDLE;
            column_reg  <= '0;
            page_reg    <= '0;
            left_reg    <= '0;
            id_seen_reg <= '0;
        end
        else if (accept)
        begin
            op_reg      <= op_next;
            phase_reg   <= phase_next;
            column_reg  <= column_next;
            page_reg    <= page_next;
            left_reg    <= left_next;
            id_seen_reg <= id_seen_next;
        end
    end

    // next state and job classification
    always_comb
    begin
        op_next      = op_reg;
        phase_next   = phase_reg;
        column_next  = column_reg;
        page_next    = page_reg;
        left_next    = left_reg;
        id_seen_next = id_seen_reg;

        job          = '0;
        job.pre      = PRE_NONE;
        job.pre_byte = item.data_byte;
        job.cs_on    = 1'b0;
        job.body     = BODY_DONE;
        job.col      = 16'(column_reg);
        job.page     = page_reg;
        job.status   = ST_REJECTED;

        if (phase_reg == PH_IDLE)
        begin
            if (req <= REQ_ID)
            begin
                column_next  = start_col;
                page_next    = start_page;
                left_next    = item.byte_count;
                id_seen_next = '0;
                job.col      = 16'(start_col);
                job.page     = start_page;
                if (req == REQ_ERASE && misaligned)
                begin
                    job.status = ST_MISALIGNED;
                end
                else if (req <= REQ_ERASE && item.byte_count == '0)
                begin
                    job.status = ST_OK;
                end
                else
                begin
                    op_next   = op_t'(item.req_type);
                    job.cs_on = 1'b1;
                    unique case (req)
                        REQ_READ:
                        begin
                            job.body   = BODY_READ;
                            phase_next = PH_READY;
                        end
                        REQ_PROG:
                        begin
                            job.body   = BODY_PROG;
                            phase_next = PH_HOST;
                        end
                        REQ_ERASE:
                        begin
                            job.body   = BODY_ERASE;
                            phase_next = PH_READY;
                        end
                        REQ_BAD:
                        begin
                            column_next = PAGE_END;
                            job.col     = 16'(PAGE_END);
                            job.body    = BODY_READ;
                            phase_next  = PH_READY;
                        end
                        default:
                        begin
                            job.body   = BODY_ID;
                            phase_next = PH_FLASH;
                        end
                    endcase
                end
            end
        end
        else if (req == REQ_READY && phase_reg == PH_READY)
        begin
            // flash finished its busy period
            if (op_reg == OP_READ || op_reg == OP_BAD)
            begin
                job.body   = BODY_STROBE;
                phase_next = PH_FLASH;
            end
            else if (op_reg == OP_PROG)
            begin
                if (left_reg == '0)
                begin
                    job.body   = BODY_FINISH;
                    job.status = ST_OK;
                    op_next    = OP_IDLE;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    column_next = '0;
                    page_next   = page_inc;
                    job.col     = '0;
                    job.page    = page_inc;
                    job.body    = BODY_PROG;
                    phase_next  = PH_HOST;
                end
            end
            else
            begin
                if (left_reg <= BLOCK_BYTES)
                begin
                    left_next  = '0;
                    job.body   = BODY_FINISH;
                    job.status = ST_OK;
                    op_next    = OP_IDLE;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    left_next  = left_reg - BLOCK_BYTES;
                    page_next  = page_reg + BLOCK_PAGES;
                    job.page   = page_reg + BLOCK_PAGES;
                    job.body   = BODY_ERASE;
                    phase_next = PH_READY;
                end
            end
        end
        else if (req == REQ_FLASH && phase_reg == PH_FLASH)
        begin
            // byte returned by the flash
            if (op_reg == OP_BAD)
            begin
                job.body   = BODY_FINISH;
                job.status = (item.data_byte != GOOD_BLOCK_MARK) ? ST_BAD_BLOCK : ST_OK;
                op_next    = OP_IDLE;
                phase_next = PH_IDLE;
            end
            else if (op_reg == OP_ID)
            begin
                job.pre      = PRE_HOST;
                id_seen_next = id_inc;
                if (id_inc >= ID_LAST)
                begin
                    job.body   = BODY_FINISH;
                    job.status = ST_OK;
                    op_next    = OP_IDLE;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    job.body = BODY_STROBE;
                end
            end
            else
            begin
                job.pre     = PRE_HOST;
                column_next = col_inc;
                left_next   = left_dec;
                if (left_dec == '0)
                begin
                    job.body   = BODY_FINISH;
                    job.status = ST_OK;
                    op_next    = OP_IDLE;
                    phase_next = PH_IDLE;
                end
                else if (col_inc >= PAGE_END)
                begin
                    column_next = '0;
                    page_next   = page_inc;
                    job.col     = '0;
                    job.page    = page_inc;
                    job.body    = BODY_READ;
                    phase_next  = PH_READY;
                end
                else
                begin
                    job.body = BODY_STROBE;
                end
            end
        end
        else if (req == REQ_HOST && phase_reg == PH_HOST)
        begin
            // host byte to program
            job.pre     = PRE_WDATA;
            column_next = col_inc;
            left_next   = left_dec;
            if (left_dec == '0 || col_inc >= PAGE_END)
            begin
                job.body   = BODY_CMD10;
                phase_next = PH_READY;
            end
            else
            begin
                job.body = BODY_NONE;
            end
        end

        job.len = LEN_W'(job.pre != PRE_NONE) + LEN_W'(job.cs_on) + body_len(job.body);
    end

`ifndef ASSERT_OFF
    a_idle_match: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) == (op_reg == OP_IDLE))
        else $error("operation and phase disagree on idle");
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= PAGE_END)
        else $error("column beyond page end");
`endif

endmodule

`default_nettype wire

### rtl/ncs_queue.sv
// short job queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module ncs_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ncs_pkg::job_t  job_in,
    output logic                full,
    input  wire logic           pop,
    output ncs_pkg::queue_head_t head
);
    import ncs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head.valid))
        else $error("job queue read while empty");
`endif

endmodule

`default_nettype wire

### rtl/ncs_back.sv
// back end: expands each job into result beats, one per cycle while result_stall is low
`timescale 1ns / 1ps
`default_nettype none

module ncs_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ncs_pkg::queue_head_t head,
    output logic                     pop,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output ncs_pkg::result_t         result
);
    import ncs_pkg::*;

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg;

    job_t             cur;
    logic             has_pre;
    logic [LEN_W-1:0] cs_pos;
    logic [LEN_W-1:0] body_idx;
    kind_t            beat_kind;
    logic [7:0]       beat_byte;
    status_t          beat_status;
    logic             beat_last;
    logic             load;
    logic [7:0]       col_lo, col_hi, row0, row1, row2;

    assign cur      = head.job;
    assign has_pre  = (cur.pre != PRE_NONE);
    assign cs_pos   = LEN_W'(has_pre);
    assign body_idx = idx_reg - cs_pos - LEN_W'(cur.cs_on);
    assign col_lo   = cur.col[7:0];
    assign col_hi   = cur.col[15:8];
    assign row0     = cur.page[7:0];
    assign row1     = cur.page[15:8];
    assign row2     = {7'b0, cur.page[16]};

    // beat generator for the job at the queue head
    always_comb
    begin
        beat_kind   = K_DONE;
        beat_byte   = '0;
        beat_status = ST_OK;
        if (has_pre && idx_reg == '0)
        begin
            beat_kind = (cur.pre == PRE_HOST) ? K_HOST : K_WDATA;
            beat_byte = cur.pre_byte;
        end
        else if (cur.cs_on && idx_reg == cs_pos)
        begin
            beat_kind = K_CSON;
        end
        else
        begin
            unique case (cur.body)
                BODY_READ, BODY_PROG:
                begin
                    // setup command, two column bytes, three row bytes, then the start command for reads
                    case (body_idx)
                        4'd0:
                        begin
                            beat_kind = K_CMD;
                            beat_byte = (cur.body == BODY_READ) ? CMD_READ_SETUP
                                                                 : CMD_PROG_SETUP;
                        end
                        4'd1: begin beat_kind = K_ADDR; beat_byte = col_lo; end
                        4'd2: begin beat_kind = K_ADDR; beat_byte = col_hi; end
                        4'd3: begin beat_kind = K_ADDR; beat_byte = row0; end
                        4'd4: begin beat_kind = K_ADDR; beat_byte = row1; end
                        4'd5: begin beat_kind = K_ADDR; beat_byte = row2; end
                        default:
                        begin
                            beat_kind = K_CMD;
                            beat_byte = CMD_READ_START;
                        end
                    endcase
                end
                BODY_ERASE:
                begin
                    case (body_idx)
                        4'd0: begin beat_kind = K_CMD;  beat_byte = CMD_ERASE_SETUP; end
                        4'd1: begin beat_kind = K_ADDR; beat_byte = row0; end
                        4'd2: begin beat_kind = K_ADDR; beat_byte = row1; end
                        4'd3: begin beat_kind = K_ADDR; beat_byte = row2; end
                        default:
                        begin
                            beat_kind = K_CMD;
                            beat_byte = CMD_ERASE_START;
                        end
                    endcase
                end
                BODY_ID:
                begin
                    case (body_idx)
                        4'd0: begin beat_kind = K_CMD;  beat_byte = CMD_READ_ID; end
                        4'd1: begin beat_kind = K_ADDR; beat_byte = ID_ADDR_BYTE; end
                        default: beat_kind = K_STROBE;
                    endcase
                end
                BODY_STROBE:
                begin
                    beat_kind = K_STROBE;
                end
                BODY_FINISH:
                begin
                    if (body_idx == '0)
                    begin
                        beat_kind = K_CSOFF;
                    end
                    else
                    begin
                        beat_kind   = K_DONE;
                        beat_status = cur.status;
                    end
                end
                BODY_CMD10:
                begin
                    beat_kind = K_CMD;
                    beat_byte = CMD_PROG_START;
                end
                default:
                begin
                    beat_kind   = K_DONE;
                    beat_status = cur.status;
                end
            endcase
        end
    end

    assign beat_last = (idx_reg == cur.len - LEN_W'(1));

    // output register advances when empty or taken, with a job at the queue head
    assign load = head.valid && (!result_valid_reg || !result_stall);
    assign pop  = load && beat_last;

    always_comb
    begin
        idx_next          = idx_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (load)
        begin
            result_valid_next = 1'b1;
            idx_next          = beat_last ? '0 : idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.out_kind <= beat_kind;
            result_reg.out_byte <= beat_byte;
            result_reg.status   <= beat_status;
            result_reg.last     <= beat_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (idx_reg < cur.len))
        else $error("beat index past end of job");
    a_idx_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !head.valid |-> (idx_reg == '0))
        else $error("beat index left over with no job");
`endif

endmodule

`default_nettype wire

### rtl/nand_flash_command_sequencer_core.sv
// top level of the nand flash command sequencer
//
//   channel   direction  payload            handshake
//   item      in         ncs_pkg::item_t    item_valid / item_stall
//   result    out        ncs_pkg::result_t  result_valid / result_stall
//
// the front end takes one item per cycle while the queue is not full and turns it into one job.
// the back end sends one result beat per cycle while result_stall is low; an item
// gives as many results as its job has beats: 1 to 3 for byte transfers, 8 when a read
// byte ends a page and starts the next page, up to 8 for commands.
// a four-entry job queue sits between them; item_stall rises when it is full.
// result_stall holds the output register; reset clears all control state
// at once, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module nand_flash_command_sequencer_core #(
    parameter int PAGE_BYTES      = ncs_pkg::PAGE_BYTES_DEF,
    parameter int PAGES_PER_BLOCK = ncs_pkg::PAGES_PER_BLOCK_DEF,
    parameter int ID_BYTES        = ncs_pkg::ID_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire ncs_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output ncs_pkg::result_t       result
);
    import ncs_pkg::*;

    logic        push;
    logic        full;
    logic        pop;
    job_t        job;
    queue_head_t head;

    // request classification and operation state
    ncs_front #(
        .PAGE_BYTES      (PAGE_BYTES),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .ID_BYTES        (ID_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .job        (job),
        .full       (full)
    );

    // job queue
    ncs_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (job),
        .full   (full),
        .pop    (pop),
        .head   (head)
    );

    // bus cycle and host result generation
    ncs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### tb/sv/ncs_result_checker.sv
// result checker for the nand command sequencer: predicts bus and host beats and compares
`timescale 1ns / 1ps

module ncs_result_checker
    import ncs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_stall,
    input  wire item_t   item,
    input  wire logic    result_valid,
    input  wire logic    result_stall,
    input  wire result_t result,
    output int           failures,
    output int           backlog,
    output int           items_taken,
    output int           beats_taken
);

    localparam int unsigned PAGE      = PAGE_BYTES_DEF;
    localparam int unsigned BLOCK     = PAGE_BYTES_DEF * PAGES_PER_BLOCK_DEF;
    localparam int unsigned MAX_BEATS = 9;

    // sequencer state as the predictor sees it
    op_t               mode      = OP_IDLE;
    phase_t            waiting   = PH_IDLE;
    logic [11:0]       column    = '0;
    logic [PAGE_W-1:0] page      = '0;
    logic [COUNT_W-1:0] remaining = '0;
    int unsigned       id_count  = 0;

    // beats of the current item, and beats still due from the block
    result_t step_beats[$];
    result_t beats_due[$];

    int n_fail  = 0;
    int n_items = 0;
    int n_beats = 0;

    function automatic void add_beat(kind_t k, logic [7:0] b, status_t s);
        result_t r;
        if (step_beats.size() < MAX_BEATS)
        begin
            r.out_kind = k;
            r.out_byte = b;
            r.status   = s;
            r.last     = 1'b0;
            step_beats.push_back(r);
        end
    endfunction

    function automatic void finish_op(status_t s);
        add_beat(K_CSOFF, 8'h00, ST_OK);
        add_beat(K_DONE, 8'h00, s);
        mode    = OP_IDLE;
        waiting = PH_IDLE;
    endfunction

    // column then row address cycles
    function automatic void send_address();
        add_beat(K_ADDR, column[7:0], ST_OK);
        add_beat(K_ADDR, {4'h0, column[11:8]}, ST_OK);
        add_beat(K_ADDR, page[7:0], ST_OK);
        add_beat(K_ADDR, page[15:8], ST_OK);
        add_beat(K_ADDR, {7'h00, page[16]}, ST_OK);
    endfunction

    function automatic void read_page_cmd();
        add_beat(K_CMD, CMD_READ_SETUP, ST_OK);
        send_address();
        add_beat(K_CMD, CMD_READ_START, ST_OK);
        waiting = PH_READY;
    endfunction

    function automatic void prog_page_cmd();
        add_beat(K_CMD, CMD_PROG_SETUP, ST_OK);
        send_address();
        waiting = PH_HOST;
    endfunction

    function automatic void erase_block_cmd();
        add_beat(K_CMD, CMD_ERASE_SETUP, ST_OK);
        add_beat(K_ADDR, page[7:0], ST_OK);
        add_beat(K_ADDR, page[15:8], ST_OK);
        add_beat(K_ADDR, {7'h00, page[16]}, ST_OK);
        add_beat(K_CMD, CMD_ERASE_START, ST_OK);
        waiting = PH_READY;
    endfunction

    // new request while idle
    function automatic void start_request(req_t rq, int unsigned addr, int unsigned cnt);
        column    = 12'(addr % PAGE);
        page      = PAGE_W'(addr / PAGE);
        remaining = COUNT_W'(cnt);
        id_count  = 0;
        if (rq == REQ_ERASE && ((addr % BLOCK) != 0 || (cnt % BLOCK) != 0))
        begin
            add_beat(K_DONE, 8'h00, ST_MISALIGNED);
            return;
        end
        if (rq <= REQ_ERASE && cnt == 0)
        begin
            add_beat(K_DONE, 8'h00, ST_OK);
            return;
        end
        mode = op_t'(rq);
        add_beat(K_CSON, 8'h00, ST_OK);
        case (rq)
            REQ_READ:  read_page_cmd();
            REQ_PROG:  prog_page_cmd();
            REQ_ERASE: erase_block_cmd();
            REQ_BAD:
            begin
                // first spare byte sits just past the page data
                column = 12'(PAGE);
                read_page_cmd();
            end
            default:
            begin
                add_beat(K_CMD, CMD_READ_ID, ST_OK);
                add_beat(K_ADDR, ID_ADDR_BYTE, ST_OK);
                add_beat(K_STROBE, 8'h00, ST_OK);
                waiting = PH_FLASH;
            end
        endcase
    endfunction

    function automatic void on_ready();
        if (mode == OP_READ || mode == OP_BAD)
        begin
            add_beat(K_STROBE, 8'h00, ST_OK);
            waiting = PH_FLASH;
        end
        else if (mode == OP_PROG)
        begin
            if (remaining == 0)
                finish_op(ST_OK);
            else
            begin
                column = '0;
                page   = page + PAGE_W'(1);
                prog_page_cmd();
            end
        end
        else
        begin
            if (remaining <= BLOCK)
            begin
                remaining = '0;
                finish_op(ST_OK);
            end
            else
            begin
                remaining = remaining - COUNT_W'(BLOCK);
                page      = page + PAGE_W'(PAGES_PER_BLOCK_DEF);
                erase_block_cmd();
            end
        end
    endfunction

    function automatic void on_flash(logic [7:0] db);
        if (mode == OP_BAD)
        begin
            if (db != GOOD_BLOCK_MARK)
                finish_op(ST_BAD_BLOCK);
            else
                finish_op(ST_OK);
        end
        else if (mode == OP_ID)
        begin
            add_beat(K_HOST, db, ST_OK);
            id_count++;
            if (id_count >= ID_BYTES_DEF)
                finish_op(ST_OK);
            else
                add_beat(K_STROBE, 8'h00, ST_OK);
        end
        else
        begin
            add_beat(K_HOST, db, ST_OK);
            column = column + 12'(1);
            if (remaining > 0)
                remaining = remaining - COUNT_W'(1);
            if (remaining == 0)
                finish_op(ST_OK);
            else if (column >= PAGE)
            begin
                // read goes on at the start of the next page
                column = '0;
                page   = page + PAGE_W'(1);
                read_page_cmd();
            end
            else
                add_beat(K_STROBE, 8'h00, ST_OK);
        end
    endfunction

    function automatic void on_host(logic [7:0] db);
        add_beat(K_WDATA, db, ST_OK);
        column = column + 12'(1);
        if (remaining > 0)
            remaining = remaining - COUNT_W'(1);
        if (remaining == 0 || column >= PAGE)
        begin
            add_beat(K_CMD, CMD_PROG_START, ST_OK);
            waiting = PH_READY;
        end
    endfunction

    // expected beats for one accepted item
    function automatic void plan_beats(item_t it);
        req_t rq;
        rq = req_t'(it.req_type);
        step_beats.delete();
        if (waiting == PH_IDLE)
        begin
            if (rq <= REQ_ID)
                start_request(rq, 32'(it.start_addr), 32'(it.byte_count));
            else
                add_beat(K_DONE, 8'h00, ST_REJECTED);
        end
        else if (rq == REQ_READY && waiting == PH_READY)
            on_ready();
        else if (rq == REQ_FLASH && waiting == PH_FLASH)
            on_flash(it.data_byte);
        else if (rq == REQ_HOST && waiting == PH_HOST)
            on_host(it.data_byte);
        else
            add_beat(K_DONE, 8'h00, ST_REJECTED);
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            beats_due.push_back(step_beats[i]);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    function automatic void compare_beat(result_t got);
        result_t want;
        if (beats_due.size() == 0)
        begin
            $error("result beat with no beat due: kind %0d byte %0d status %0d",
                   got.out_kind, got.out_byte, got.status);
            n_fail++;
            return;
        end
        want = beats_due.pop_front();
        check_field("out_kind", 8'(want.out_kind), 8'(got.out_kind));
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("last", 8'(want.last), 8'(got.last));
    endfunction

    // watch both channels on every edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mode      = OP_IDLE;
            waiting   = PH_IDLE;
            column    = '0;
            page      = '0;
            remaining = '0;
            id_count  = 0;
            beats_due.delete();
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                plan_beats(item);
                n_items++;
            end
            if (result_valid && !result_stall)
            begin
                compare_beat(result);
                n_beats++;
            end
        end
        failures    <= n_fail;
        backlog     <= beats_due.size();
        items_taken <= n_items;
        beats_taken <= n_beats;
    end

endmodule

### tb/sv/nand_flash_command_sequencer_core_tb.sv
// testbench top for the nand command sequencer: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module nand_flash_command_sequencer_core_tb;
    import ncs_pkg::*;

    localparam int unsigned PAGE         = PAGE_BYTES_DEF;
    localparam int unsigned BLOCK        = PAGE_BYTES_DEF * PAGES_PER_BLOCK_DEF;
    localparam int unsigned LAST_BLOCK   = (1 << ADDR_W) / BLOCK - 1;
    localparam int          RANDOM_ITEMS = 345;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 24;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    item_t   item         = '0;
    logic    result_stall = 1'b0;
    logic    item_stall;
    logic    result_valid;
    result_t result;

    int send_gap_pct = 23;
    int recv_gap_pct = 56;
    int hold_asked   = 0;
    int hold_done    = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    int fail_total;
    int backlog;
    int items_seen;
    int beats_seen;

    nand_flash_command_sequencer_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ncs_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .failures     (fail_total),
        .backlog      (backlog),
        .items_taken  (items_seen),
        .beats_taken  (beats_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_done < hold_asked)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
            end
            else
                result_stall <= ($urandom_range(99, 0) < recv_gap_pct);
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("nand_flash_command_sequencer_core_tb NOT OK");
            $finish;
        end
    end

    function automatic item_t make_item(req_t r, logic [ADDR_W-1:0] addr,
                                        logic [COUNT_W-1:0] cnt, logic [7:0] db);
        item_t it;
        it.req_type   = r;
        it.start_addr = addr;
        it.byte_count = cnt;
        it.data_byte  = db;
        return it;
    endfunction

    function automatic logic [COUNT_W-1:0] any_count();
        if ($urandom_range(7, 0) == 0)
            return COUNT_W'(1 << ADDR_W);
        return COUNT_W'($urandom_range(1 << ADDR_W, 0));
    endfunction

    // address close to a page end half the time so transfers cross pages
    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(1, 0) == 0)
            return ADDR_W'($urandom);
        return ADDR_W'($urandom_range((1 << PAGE_W) - 1, 0) * PAGE + PAGE
                       - $urandom_range(6, 1));
    endfunction

    function automatic int unsigned pick_len();
        if ($urandom_range(9, 0) == 0)
            return $urandom_range(40, 12);
        return $urandom_range(12, 1);
    endfunction

    // one beat on the item channel, with random sender gaps
    task automatic send_item(item_t it);
        while ($urandom_range(99, 0) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // awaited event, sometimes preceded by one the block does not wait for
    task automatic feed(req_t want, logic [7:0] db);
        req_t r;
        if ($urandom_range(99, 0) < 8)
        begin
            do
                r = req_t'($urandom_range(7, 0));
            while (r == want);
            send_item(make_item(r, ADDR_W'($urandom), any_count(), 8'($urandom)));
        end
        send_item(make_item(want, ADDR_W'($urandom), any_count(), db));
    endtask

    task automatic run_read(logic [ADDR_W-1:0] addr, int unsigned cnt);
        int unsigned col;
        int unsigned left;
        int unsigned n;
        send_item(make_item(REQ_READ, addr, COUNT_W'(cnt), 8'($urandom)));
        col  = addr % PAGE;
        left = cnt;
        while (left > 0)
        begin
            feed(REQ_READY, 8'($urandom));
            n = (left < PAGE - col) ? left : PAGE - col;
            repeat (n) feed(REQ_FLASH, 8'($urandom));
            left -= n;
            col   = 0;
        end
    endtask

    task automatic run_prog(logic [ADDR_W-1:0] addr, int unsigned cnt);
        int unsigned col;
        int unsigned left;
        int unsigned n;
        send_item(make_item(REQ_PROG, addr, COUNT_W'(cnt), 8'($urandom)));
        col  = addr % PAGE;
        left = cnt;
        do
        begin
            n = (left < PAGE - col) ? left : PAGE - col;
            repeat (n) feed(REQ_HOST, 8'($urandom));
            left -= n;
            col   = 0;
            feed(REQ_READY, 8'($urandom));
        end
        while (left > 0);
    endtask

    task automatic run_erase(int unsigned blk, int unsigned blocks);
        send_item(make_item(REQ_ERASE, ADDR_W'(blk * BLOCK), COUNT_W'(blocks * BLOCK),
                            8'($urandom)));
        repeat (blocks) feed(REQ_READY, 8'($urandom));
    endtask

    task automatic run_bad(logic [7:0] mark);
        send_item(make_item(REQ_BAD, ADDR_W'($urandom), any_count(), 8'($urandom)));
        feed(REQ_READY, 8'($urandom));
        feed(REQ_FLASH, mark);
    endtask

    task automatic run_id();
        send_item(make_item(REQ_ID, ADDR_W'($urandom), any_count(), 8'($urandom)));
        repeat (ID_BYTES_DEF) feed(REQ_FLASH, 8'($urandom));
    endtask

    // single-beat requests: zero lengths and misaligned erases
    task automatic run_short_request();
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] cnt;
        addr = ADDR_W'($urandom);
        if ($urandom_range(3, 0) == 0)
            send_item(make_item(req_t'($urandom_range(2, 0)), addr, '0, 8'($urandom)));
        else
        begin
            cnt = any_count();
            if (addr % BLOCK == 0 && cnt % BLOCK == 0)
                addr[0] = 1'b1;
            send_item(make_item(REQ_ERASE, addr, cnt, 8'($urandom)));
        end
    endtask

    // main stimulus and verdict
    initial
    begin
        int base;
        int stage;
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // events while idle
        send_item(make_item(REQ_READY, '0, '0, 8'h00));
        send_item(make_item(REQ_HOST, ADDR_W'('1), COUNT_W'(1 << ADDR_W), 8'hFF));
        // zero lengths
        send_item(make_item(REQ_READ, ADDR_W'('1), '0, 8'h00));
        send_item(make_item(REQ_PROG, ADDR_W'(PAGE), '0, 8'h00));
        send_item(make_item(REQ_ERASE, '0, '0, 8'h00));
        // misaligned erase at the field extremes
        send_item(make_item(REQ_ERASE, ADDR_W'('1), COUNT_W'(1 << ADDR_W), 8'h00));
        // read id with a busy request and a stray event in the middle
        send_item(make_item(REQ_ID, ADDR_W'('1), COUNT_W'('1), 8'h00));
        send_item(make_item(REQ_READ, '0, COUNT_W'(1), 8'h00));
        send_item(make_item(REQ_READY, '0, '0, 8'h00));
        for (int i = 0; i < ID_BYTES_DEF; i++)
            send_item(make_item(REQ_FLASH, '0, '0,
                                (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom)));
        // bad-block check that finds a marked block
        send_item(make_item(REQ_BAD, '0, '0, 8'h00));
        send_item(make_item(REQ_READY, '0, '0, 8'h00));
        send_item(make_item(REQ_FLASH, '0, '0, 8'h00));
        // last page wraps to page zero, program across a page end
        run_read(ADDR_W'('1), 2);
        run_prog(ADDR_W'(PAGE - 1), 2);

        // random sequences in three pacing stages
        base       = items_sent;
        stage      = 1;
        hold_asked = 1;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            if (stage == 1 && items_sent >= base + RANDOM_ITEMS / 3)
            begin
                stage        = 2;
                send_gap_pct = 56;
                recv_gap_pct = 23;
            end
            else if (stage == 2 && items_sent >= base + 2 * RANDOM_ITEMS / 3)
            begin
                stage        = 3;
                send_gap_pct = 0;
                recv_gap_pct = 0;
                hold_asked   = 2;
            end
            pick = $urandom_range(99, 0);
            if (pick < 30)
                run_read(pick_addr(), pick_len());
            else if (pick < 60)
                run_prog(pick_addr(), pick_len());
            else if (pick < 72)
                run_erase(($urandom_range(3, 0) == 0) ? LAST_BLOCK
                                                       : $urandom_range(LAST_BLOCK, 0),
                          $urandom_range(3, 1));
            else if (pick < 82)
                run_bad(($urandom_range(1, 0) == 0) ? GOOD_BLOCK_MARK : 8'($urandom));
            else if (pick < 90)
                run_id();
            else if (pick < 95)
                run_short_request();
            else
                send_item(make_item(req_t'($urandom_range(7, 5)), ADDR_W'($urandom),
                                    any_count(), 8'($urandom)));
        end
        item_valid <= 1'b0;

        // drain, then leave room for any stray beat
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d result beats from %0d items over reads, programs, erases,",
                 beats_seen, items_seen);
        $display("bad-block checks and id reads, with stray events and %0d long hold-offs",
                 hold_done);
        if (fail_total == 0 && backlog == 0)
            $display("nand_flash_command_sequencer_core_tb OK");
        else
            $display("nand_flash_command_sequencer_core_tb NOT OK");
        $finish;
    end

endmodule
